// File: rtl/text_console_cursor_engine_unit_assert.svh
// assertion helpers for the console engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// next-cycle implication, checked out of reset
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

// File: rtl/tcce_pkg.sv
package tcce_pkg;

    localparam int VIDEO_CELLS    = 16384;
    localparam int CONSOLES       = 4;
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_CELLS   = 2000;

    localparam int REGION_CELLS = VIDEO_CELLS / CONSOLES;

    localparam int ADDR_W = 14;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    localparam int CIDX_W = $clog2(CONSOLES);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);

    // last cell of a region as row and column
    localparam int LAST_ROW = (REGION_CELLS - 1) / SCREEN_COLUMNS;
    localparam int LAST_COL = (REGION_CELLS - 1) % SCREEN_COLUMNS;
    localparam int ROW_W    = $clog2(LAST_ROW + 2);

    // visible window size as row and column
    localparam int SCR_ROW = SCREEN_CELLS / SCREEN_COLUMNS;
    localparam int SCR_COL = SCREEN_CELLS % SCREEN_COLUMNS;

    // highest view row the view may reach inside a region
    localparam int VIEW_ROW_MAX = (REGION_CELLS > SCREEN_CELLS) ?
        (REGION_CELLS - SCREEN_CELLS + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS : 0;
    localparam int VROW_W = $clog2(VIEW_ROW_MAX + 1);

    localparam int NL_LIMIT = REGION_CELLS - SCREEN_COLUMNS;
    localparam int TAB_STEP = 4;

    localparam logic [CMD_W-1:0] CMD_PUT         = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    localparam int                PADDR_W         = 3;
    localparam int                REG_SEL_LSB     = 2;
    localparam logic              REG_TEXT_ATTR   = 1'b0;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  console_index;
        logic [CHAR_W-1:0] char_code;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] char_val;
        logic [ATTR_W-1:0] attr;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] view;
        logic              last;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } edit_t;

endpackage

// File: rtl/tcce_in_stage.sv
module tcce_in_stage
    import tcce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [IDX_W-1:0]  s_console_index,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic              take,
    output logic              item_valid,
    output item_t             item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command       <= s_command;
            item_reg.console_index <= s_console_index;
            item_reg.char_code     <= s_char_code;
        end
    end

endmodule

// File: rtl/tcce_edit.sv
module tcce_edit
    import tcce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  item_t             item,
    input  logic              commit,
    input  logic [ATTR_W-1:0] text_attr,
    output edit_t             edit
);

    // cursor kept as row and column inside the region, view as a row number
    logic [ROW_W-1:0]  row_reg  [CONSOLES];
    logic [COL_W-1:0]  col_reg  [CONSOLES];
    logic [VROW_W-1:0] vrow_reg [CONSOLES];

    logic [CIDX_W-1:0] sel;
    logic              in_range;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [VROW_W-1:0] cur_vrow;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic [VROW_W-1:0] vrow_next;
    logic [1:0]        n_writes;
    logic              first_old;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] old_abs;
    logic [ADDR_W-1:0] cur_abs;
    logic [ADDR_W-1:0] view_abs;
    int                cur_off;
    int                t_row;

    assign sel      = item.console_index[CIDX_W-1:0];
    assign in_range = (int'(item.console_index) < CONSOLES);
    assign cur_row  = row_reg[sel];
    assign cur_col  = col_reg[sel];
    assign cur_vrow = vrow_reg[sel];
    assign cur_off  = int'(cur_row) * SCREEN_COLUMNS + int'(cur_col);

    always_comb begin
        row_next  = cur_row;
        col_next  = cur_col;
        vrow_next = cur_vrow;
        n_writes  = 2'd0;
        first_old = 1'b0;
        t_row     = 0;
        case (item.command)
            CMD_PUT: begin
                case (item.char_code)
                    CH_NEWLINE: begin
                        if (cur_off < NL_LIMIT) begin
                            row_next = cur_row + 1'b1;
                            col_next = '0;
                            n_writes = 2'd1;
                        end
                    end
                    CH_BACKSPACE: begin
                        if (cur_off != 0) begin
                            n_writes = 2'd1;
                            if (cur_col == '0) begin
                                row_next = cur_row - 1'b1;
                                col_next = COL_W'(SCREEN_COLUMNS - 1);
                            end else begin
                                col_next = cur_col - 1'b1;
                            end
                        end
                    end
                    CH_TAB: begin
                        if (cur_off < REGION_CELLS - 1) begin
                            n_writes = 2'd1;
                            // wrap to the start of the next row when four or fewer cells remain in the row
                            if (int'(cur_col) + TAB_STEP >= SCREEN_COLUMNS) begin
                                row_next = cur_row + 1'b1;
                                col_next = '0;
                            end else begin
                                col_next = COL_W'(int'(cur_col) + TAB_STEP);
                            end
                            if (int'(row_next) > LAST_ROW ||
                                (int'(row_next) == LAST_ROW && int'(col_next) > LAST_COL)) begin
                                row_next = ROW_W'(LAST_ROW);
                                col_next = COL_W'(LAST_COL);
                            end
                        end
                    end
                    CH_BELL: begin
                    end
                    default: begin
                        if (cur_off < REGION_CELLS - 1) begin
                            n_writes  = 2'd2;
                            first_old = 1'b1;
                            if (int'(cur_col) == SCREEN_COLUMNS - 1) begin
                                row_next = cur_row + 1'b1;
                                col_next = '0;
                            end else begin
                                col_next = cur_col + 1'b1;
                            end
                        end
                    end
                endcase
                // scroll straight to the first view row that shows the cursor
                if (int'(row_next) > SCR_ROW ||
                    (int'(row_next) == SCR_ROW && int'(col_next) >= SCR_COL)) begin
                    t_row = int'(row_next) - SCR_ROW + ((int'(col_next) >= SCR_COL) ? 1 : 0);
                    if (int'(cur_vrow) < VIEW_ROW_MAX && t_row > int'(cur_vrow)) begin
                        vrow_next = (t_row > VIEW_ROW_MAX) ? VROW_W'(VIEW_ROW_MAX)
                                                           : VROW_W'(t_row);
                    end
                end
            end
            CMD_SCROLL_UP: begin
                if (cur_vrow != '0) begin
                    vrow_next = cur_vrow - 1'b1;
                end
            end
            CMD_SCROLL_DOWN: begin
                if (int'(cur_vrow) < VIEW_ROW_MAX) begin
                    vrow_next = cur_vrow + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign base     = ADDR_W'(int'(item.console_index) * REGION_CELLS);
    assign old_abs  = base + ADDR_W'(cur_off);
    assign cur_abs  = base + ADDR_W'(int'(row_next) * SCREEN_COLUMNS + int'(col_next));
    assign view_abs = base + ADDR_W'(int'(vrow_next) * SCREEN_COLUMNS);

    always_comb begin
        edit = '0;
        if (!in_range) begin
            edit.first.last = 1'b1;
        end else begin
            edit.first.cursor = cur_abs;
            edit.first.view   = view_abs;
            edit.first.last   = (n_writes != 2'd2);
            if (n_writes != 2'd0) begin
                edit.first.we       = 1'b1;
                edit.first.addr     = first_old ? old_abs : cur_abs;
                edit.first.char_val = first_old ? item.char_code : CH_BLANK;
                edit.first.attr     = text_attr;
            end
            edit.second.we       = 1'b1;
            edit.second.addr     = cur_abs;
            edit.second.char_val = CH_BLANK;
            edit.second.attr     = text_attr;
            edit.second.cursor   = cur_abs;
            edit.second.view     = view_abs;
            edit.second.last     = 1'b1;
            edit.two             = (n_writes == 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CONSOLES; i++) begin
                row_reg[i]  <= '0;
                col_reg[i]  <= '0;
                vrow_reg[i] <= '0;
            end
        end else if (commit && in_range) begin
            row_reg[sel]  <= row_next;
            col_reg[sel]  <= col_next;
            vrow_reg[sel] <= vrow_next;
        end
    end

endmodule

// File: rtl/tcce_out_stage.sv
`include "text_console_cursor_engine_unit_assert.svh"

module tcce_out_stage
    import tcce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  edit_t             edit,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_enable,
    output logic [ADDR_W-1:0] m_cell_address,
    output logic [CHAR_W-1:0] m_cell_char,
    output logic [ATTR_W-1:0] m_cell_attribute,
    output logic [ADDR_W-1:0] m_cursor_position,
    output logic [ADDR_W-1:0] m_view_start,
    output logic              m_last
);

    logic    m_valid_reg;
    logic    pend_reg;
    result_t res_reg;
    result_t second_reg;

    // the second write of a character holds the stage until it has been taken
    assign take = item_valid && (!m_valid_reg || (m_ready && !pend_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
            pend_reg    <= edit.two;
        end else if (m_valid_reg && m_ready) begin
            if (pend_reg) begin
                pend_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg    <= edit.first;
            second_reg <= edit.second;
        end else if (m_valid_reg && m_ready && pend_reg) begin
            res_reg <= second_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_write_enable    = res_reg.we;
    assign m_cell_address    = res_reg.addr;
    assign m_cell_char       = res_reg.char_val;
    assign m_cell_attribute  = res_reg.attr;
    assign m_cursor_position = res_reg.cursor;
    assign m_view_start      = res_reg.view;
    assign m_last            = res_reg.last;

    `TCCE_ASSERT_IMPL(a_pend_needs_valid, pend_reg, m_valid_reg)
    `TCCE_ASSERT_IMPL(a_pend_not_last, m_valid_reg && pend_reg, !res_reg.last)
    `TCCE_ASSERT_NEXT(a_second_follows, m_valid_reg && m_ready && pend_reg,
                      m_valid_reg && res_reg.last && !pend_reg)

endmodule

// File: rtl/text_console_cursor_engine_unit.sv
// Text console engine: four console regions, each with a cursor and a view start.
// Input channel (s_valid/s_ready): command, console_index and char_code per item.
// Result channel (m_valid/m_ready): a cell write (or none) with the cursor and view
// start after the item; m_last marks the final result of an item.
// A printable character gives two results (the character, then a blank next cell)
// unless the cursor is on the region's last cell; every other item gives one.
// An item waits in the input register; its first result is then loaded into the
// result register, from which it is presented on the result channel.
// Throughput: one item per cycle while m_ready is high, set by the single result
// register issuing one cell write per cycle; a character's blank write holds input.
// A stalled result holds in the result register; one more item waits in the input
// register, after which s_ready drops until the result side drains.
// The APB port holds text_attribute at address 0; write it only while idle.
// Reset puts every cursor and view start at the start of its region and the
// attribute at 7; no clearing pass is needed.
module text_console_cursor_engine_unit
    import tcce_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [IDX_W-1:0]   s_console_index,
    input  logic [CHAR_W-1:0]  s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_write_enable,
    output logic [ADDR_W-1:0]  m_cell_address,
    output logic [CHAR_W-1:0]  m_cell_char,
    output logic [ATTR_W-1:0]  m_cell_attribute,
    output logic [ADDR_W-1:0]  m_cursor_position,
    output logic [ADDR_W-1:0]  m_view_start,
    output logic               m_last
);

    logic [ATTR_W-1:0] attr_reg;
    logic              item_valid;
    item_t             item;
    logic              take;
    edit_t             edit;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= TEXT_ATTR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[REG_SEL_LSB] == REG_TEXT_ATTR) begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[REG_SEL_LSB] == REG_TEXT_ATTR) begin
            prdata = {{(32 - ATTR_W){1'b0}}, attr_reg};
        end
    end

    tcce_in_stage u_in (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_console_index (s_console_index),
        .s_char_code     (s_char_code),
        .take            (take),
        .item_valid      (item_valid),
        .item            (item)
    );

    tcce_edit u_edit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .commit    (take),
        .text_attr (attr_reg),
        .edit      (edit)
    );

    tcce_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .item_valid        (item_valid),
        .edit              (edit),
        .take              (take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_write_enable    (m_write_enable),
        .m_cell_address    (m_cell_address),
        .m_cell_char       (m_cell_char),
        .m_cell_attribute  (m_cell_attribute),
        .m_cursor_position (m_cursor_position),
        .m_view_start      (m_view_start),
        .m_last            (m_last)
    );

endmodule
